// ===== rtl/etrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package etrs_pkg;

	// CORDIC iteration count and datapath widths.
	localparam int CordicSteps = 24;
	localparam int CordicW     = 34;
	localparam int PhaseW      = 32;
	localparam int OutW        = 20;

	// CORDIC gain in Q30, used as the start value of x.
	localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [29:0] AtanTab [CordicSteps] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331, 30'd21354465, 30'd10679838, 30'd5340245,
		30'd2670163, 30'd1335087, 30'd667544, 30'd333772,
		30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304,
		30'd652, 30'd326, 30'd163, 30'd81
	};

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [15:0]        angle_x;
		logic [15:0]        angle_y;
		logic [15:0]        angle_z;
		logic [15:0]        scale_x;
		logic [15:0]        scale_y;
		logic [15:0]        scale_z;
	} pose_t;

	typedef struct packed {
		logic signed [OutW-1:0] m00;
		logic signed [OutW-1:0] m01;
		logic signed [OutW-1:0] m02;
		logic signed [OutW-1:0] m10;
		logic signed [OutW-1:0] m11;
		logic signed [OutW-1:0] m12;
		logic signed [OutW-1:0] m20;
		logic signed [OutW-1:0] m21;
		logic signed [OutW-1:0] m22;
		logic signed [31:0]     trans_x;
		logic signed [31:0]     trans_y;
		logic signed [31:0]     trans_z;
	} matrix_t;

endpackage

`default_nettype wire

// ===== rtl/etrs_cordic_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One registered CORDIC micro-rotation for the three angles in parallel.
module etrs_cordic_stage #(
	parameter int STEP = 0
) (
	input  wire logic                               clk,
	input  wire logic                               en,
	input  wire logic signed [3*etrs_pkg::CordicW-1:0] x_in,
	input  wire logic signed [3*etrs_pkg::CordicW-1:0] y_in,
	input  wire logic signed [3*etrs_pkg::CordicW-1:0] z_in,
	output logic signed [3*etrs_pkg::CordicW-1:0]      x_out,
	output logic signed [3*etrs_pkg::CordicW-1:0]      y_out,
	output logic signed [3*etrs_pkg::CordicW-1:0]      z_out
);
	import etrs_pkg::*;

	logic signed [3*CordicW-1:0] x_d, y_d, z_d;

	// Rotate toward zero residual angle; arithmetic shift is a floor.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [CordicW-1:0] xv, yv, zv, dx, dy, at;
			xv = x_in[a*CordicW +: CordicW];
			yv = y_in[a*CordicW +: CordicW];
			zv = z_in[a*CordicW +: CordicW];
			dx = yv >>> STEP;
			dy = xv >>> STEP;
			at = CordicW'(AtanTab[STEP]);
			if (!zv[CordicW-1]) begin
				x_d[a*CordicW +: CordicW] = xv - dx;
				y_d[a*CordicW +: CordicW] = yv + dy;
				z_d[a*CordicW +: CordicW] = zv - at;
			end else begin
				x_d[a*CordicW +: CordicW] = xv + dx;
				y_d[a*CordicW +: CordicW] = yv - dy;
				z_d[a*CordicW +: CordicW] = zv + at;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out <= x_d;
			y_out <= y_d;
			z_out <= z_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/etrs_sincos.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined sine/cosine of three binary angles, one CORDIC step per stage.
// An input register precedes the CordicSteps stages; the stage enables come
// from the top-level valid chain so a stall freezes the whole pipe.
module etrs_sincos #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic                                 clk,
	input  wire logic [etrs_pkg::CordicSteps:0]       en,
	input  wire logic [15:0]                          angle_x,
	input  wire logic [15:0]                          angle_y,
	input  wire logic [15:0]                          angle_z,
	output logic signed [3*(FRAC_BITS+2)-1:0]         sin_out,
	output logic signed [3*(FRAC_BITS+2)-1:0]         cos_out
);
	import etrs_pkg::*;

	localparam int SW = FRAC_BITS + 2;
	localparam int RS = 30 - FRAC_BITS;
	localparam int AW = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

	logic signed [3*CordicW-1:0] xs [CordicSteps+1];
	logic signed [3*CordicW-1:0] ys [CordicSteps+1];
	logic signed [3*CordicW-1:0] zs [CordicSteps+1];
	logic [5:0] quad_p [CordicSteps+1];
	logic [PhaseW-1:0] ph [3];

	// Angle to 32-bit phase; the top two bits pick the quadrant.
	always_comb begin
		ph[0] = PhaseW'(angle_x[AW-1:0]) << (PhaseW - ANGLE_BITS);
		ph[1] = PhaseW'(angle_y[AW-1:0]) << (PhaseW - ANGLE_BITS);
		ph[2] = PhaseW'(angle_z[AW-1:0]) << (PhaseW - ANGLE_BITS);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int a = 0; a < 3; a++) begin
				xs[0][a*CordicW +: CordicW] <= CordicGain;
				ys[0][a*CordicW +: CordicW] <= '0;
				zs[0][a*CordicW +: CordicW] <= CordicW'({2'b00, ph[a][29:0]});
				quad_p[0][a*2 +: 2] <= ph[a][31:30];
			end
		end
	end

	for (genvar i = 0; i < CordicSteps; i++) begin : g_step
		etrs_cordic_stage #(.STEP(i)) u_stage (
			.clk  (clk),
			.en   (en[i+1]),
			.x_in (xs[i]),
			.y_in (ys[i]),
			.z_in (zs[i]),
			.x_out(xs[i+1]),
			.y_out(ys[i+1]),
			.z_out(zs[i+1])
		);
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				quad_p[i+1] <= quad_p[i];
			end
		end
	end

	// Round to FRAC_BITS, clamp to +-1 and fold in the quadrant.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic signed [CordicW-1:0] xr, yr, lim;
			logic signed [SW-1:0] c, s;
			lim = CordicW'(1) <<< FRAC_BITS;
			xr = ($signed(xs[CordicSteps][a*CordicW +: CordicW])
				+ (CordicW'(1) <<< (RS-1))) >>> RS;
			yr = ($signed(ys[CordicSteps][a*CordicW +: CordicW])
				+ (CordicW'(1) <<< (RS-1))) >>> RS;
			if (xr > lim) xr = lim;
			if (xr < -lim) xr = -lim;
			if (yr > lim) yr = lim;
			if (yr < -lim) yr = -lim;
			c = SW'(xr);
			s = SW'(yr);
			unique case (quad_p[CordicSteps][a*2 +: 2])
				2'd0: begin
					cos_out[a*SW +: SW] = c;
					sin_out[a*SW +: SW] = s;
				end
				2'd1: begin
					cos_out[a*SW +: SW] = -s;
					sin_out[a*SW +: SW] = c;
				end
				2'd2: begin
					cos_out[a*SW +: SW] = -c;
					sin_out[a*SW +: SW] = -s;
				end
				default: begin
					cos_out[a*SW +: SW] = s;
					sin_out[a*SW +: SW] = -c;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/euler_trs_model_matrix_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Euler Y-X-Z translate-rotate-scale model matrix unit. Takes one pose per
// clock while not stalled and returns its 3x4 model matrix, linear part
// saturated to signed Q(19-FRAC_BITS).FRAC_BITS, translation passed through
// unchanged. It accepts one transaction every cycle when not stalled; a pose
// passes the input phase register, the 24-stage CORDIC pipeline, quadrant
// fold, two product stages, scale multiply and output register. Backpressure
// stalls every stage at once, so no transaction is lost or duplicated.
module euler_trs_model_matrix_unit #(
	parameter int ANGLE_BITS = 16,
	parameter int FRAC_BITS  = 14
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire etrs_pkg::pose_t   in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output etrs_pkg::matrix_t      out_data
);
	import etrs_pkg::*;

	localparam int SW    = FRAC_BITS + 2;
	localparam int NCOR  = CordicSteps + 1;
	localparam int NPIPE = NCOR + 5;
	localparam int PW    = 3 * SW + 2;
	localparam int RW    = 2 * SW + 2;
	localparam int VW    = RW + 17;
	localparam logic signed [VW-1:0] OutMax = VW'(524287);
	localparam logic signed [VW-1:0] OutMin = -VW'(524288);

	logic [NPIPE-1:0] vld_q;
	logic [NPIPE-1:0] en;
	logic             adv;

	// Pipeline advances whenever the last stage is empty or drained.
	assign adv      = !vld_q[NPIPE-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = vld_q[NPIPE-1];

	always_comb begin
		en[0] = adv && in_valid;
		for (int i = 1; i < NPIPE; i++) en[i] = adv && vld_q[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NPIPE-2:0], in_valid};
		end
	end

	// Side data (scale, position) travels alongside the CORDIC pipe.
	pose_t side_q [NPIPE-1];
	always_ff @(posedge clk) begin
		if (en[0]) side_q[0] <= in_data;
		for (int i = 1; i < NPIPE-1; i++) if (en[i]) side_q[i] <= side_q[i-1];
	end

	logic signed [3*SW-1:0] sn, cs;
	etrs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sincos (
		.clk     (clk),
		.en      (en[NCOR-1:0]),
		.angle_x (in_data.angle_x),
		.angle_y (in_data.angle_y),
		.angle_z (in_data.angle_z),
		.sin_out (sn),
		.cos_out (cs)
	);

	logic signed [SW-1:0] sx_s1, cx_s1, sy_s1, cy_s1, sz_s1, cz_s1;
	always_ff @(posedge clk) begin
		if (en[NCOR]) begin
			sx_s1 <= sn[0 +: SW];
			sy_s1 <= sn[SW +: SW];
			sz_s1 <= sn[2*SW +: SW];
			cx_s1 <= cs[0 +: SW];
			cy_s1 <= cs[SW +: SW];
			cz_s1 <= cs[2*SW +: SW];
		end
	end

	// First products: two-term and the sx-shared terms.
	logic signed [RW-1:0] cycz_s2, sycz_s2, cysz_s2, sysz_s2, sxsz_s2, sxcz_s2;
	logic signed [RW-1:0] cxsz_s2, cxcz_s2, sycx_s2, cycx_s2, sx_s2;
	logic signed [SW-1:0] sy_s2, cy_s2;
	always_ff @(posedge clk) begin
		if (en[NCOR+1]) begin
			cycz_s2 <= RW'(cy_s1 * cz_s1);
			sycz_s2 <= RW'(sy_s1 * cz_s1);
			cysz_s2 <= RW'(cy_s1 * sz_s1);
			sysz_s2 <= RW'(sy_s1 * sz_s1);
			sxsz_s2 <= RW'(sx_s1 * sz_s1);
			sxcz_s2 <= RW'(sx_s1 * cz_s1);
			cxsz_s2 <= RW'(cx_s1 * sz_s1);
			cxcz_s2 <= RW'(cx_s1 * cz_s1);
			sycx_s2 <= RW'(sy_s1 * cx_s1);
			cycx_s2 <= RW'(cy_s1 * cx_s1);
			sx_s2   <= -(RW'(sx_s1) <<< FRAC_BITS);
			sy_s2   <= sy_s1;
			cy_s2   <= cy_s1;
		end
	end

	// Three-term entries formed at 3F fraction bits, rounded to 2F.
	logic signed [RW-1:0] r_s3 [9];
	always_ff @(posedge clk) begin
		if (en[NCOR+2]) begin
			r_s3[0] <= RW'(((PW'(cycz_s2) <<< FRAC_BITS) + sy_s2 * sxsz_s2
				+ (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			r_s3[1] <= cxsz_s2;
			r_s3[2] <= RW'((-(PW'(sycz_s2) <<< FRAC_BITS) + cy_s2 * sxsz_s2
				+ (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			r_s3[3] <= RW'((-(PW'(cysz_s2) <<< FRAC_BITS) + sy_s2 * sxcz_s2
				+ (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			r_s3[4] <= cxcz_s2;
			r_s3[5] <= RW'(((PW'(sysz_s2) <<< FRAC_BITS) + cy_s2 * sxcz_s2
				+ (PW'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS);
			r_s3[6] <= sycx_s2;
			r_s3[7] <= sx_s2;
			r_s3[8] <= cycx_s2;
		end
	end

	// Scale multiply per column.
	logic signed [VW-1:0] v_s4 [9];
	logic [15:0] scl [3];
	assign scl[0] = side_q[NCOR+2].scale_x;
	assign scl[1] = side_q[NCOR+2].scale_y;
	assign scl[2] = side_q[NCOR+2].scale_z;
	always_ff @(posedge clk) begin
		if (en[NCOR+3]) begin
			for (int k = 0; k < 9; k++)
				v_s4[k] <= VW'(r_s3[k]) * VW'(signed'({1'b0, scl[k/3]}));
		end
	end

	// Round, saturate and register the result.
	logic signed [OutW-1:0] o [9];
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			logic signed [VW-1:0] t;
			t = (v_s4[k] + (VW'(1) <<< (FRAC_BITS+11))) >>> (FRAC_BITS+12);
			if (t > OutMax) t = OutMax;
			if (t < OutMin) t = OutMin;
			o[k] = OutW'(t);
		end
	end

	always_ff @(posedge clk) begin
		if (en[NCOR+4]) begin
			out_data.m00 <= o[0];
			out_data.m01 <= o[1];
			out_data.m02 <= o[2];
			out_data.m10 <= o[3];
			out_data.m11 <= o[4];
			out_data.m12 <= o[5];
			out_data.m20 <= o[6];
			out_data.m21 <= o[7];
			out_data.m22 <= o[8];
			out_data.trans_x <= side_q[NCOR+3].pos_x;
			out_data.trans_y <= side_q[NCOR+3].pos_y;
			out_data.trans_z <= side_q[NCOR+3].pos_z;
		end
	end

	// A held result must not change while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	// Input is taken whenever the output side is free.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("ready dropped with empty output");

	// Valid count never grows during a full stall.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule

`default_nettype wire

// ===== bench/euler_trs_model_matrix_unit_tb.sv =====
`timescale 1ns / 1ps

module euler_trs_model_matrix_unit_tb;
	import etrs_pkg::*;

	localparam int AngleBits   = 16;
	localparam int FracBits    = 14;
	localparam int RandomPoses = 1600;
	localparam int IdleLimit   = 20000;
	localparam int DrainCycles = 60;
	localparam int OutMax      = 524287;
	localparam int OutMin      = -524288;

	logic    clk;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	pose_t   in_data;
	logic    out_valid;
	logic    out_ready;
	matrix_t out_data;

	matrix_t matrix_queue[$];
	int      error_count;
	int      idle_cycles;
	bit      stimulus_done;
	bit      hold_sink;
	bit      hold_done;

	// Directed rows; a row with has_known set carries its expected matrix.
	typedef struct {
		pose_t   pose;
		bit      has_known;
		matrix_t known;
	} pose_row_t;

	pose_row_t directed_rows[$];

	euler_trs_model_matrix_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock generation.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Sine and cosine of a binary angle by a 24-step CORDIC with quadrant fold.
	task automatic cordic_sin_cos(input logic [15:0] angle, output longint sn,
			output longint cs);
		logic [31:0] phase;
		longint      x, y, z, dx, dy, c, s, lim;
		logic [1:0]  quad;
		phase = 32'(angle & ((1 << AngleBits) - 1)) << (32 - AngleBits);
		quad  = phase[31:30];
		z     = longint'(phase[29:0]);
		x     = 652032874;
		y     = 0;
		lim   = longint'(1) <<< FracBits;
		for (int i = 0; i < CordicSteps; i++) begin
			dx = floor_shift(y, i);
			dy = floor_shift(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(AtanTab[i]);
			end else begin
				x += dx; y -= dy; z += longint'(AtanTab[i]);
			end
		end
		c = clip(round_half_up(x, 30 - FracBits), -lim, lim);
		s = clip(round_half_up(y, 30 - FracBits), -lim, lim);
		case (quad)
			2'd0: begin cs = c;  sn = s;  end
			2'd1: begin cs = -s; sn = c;  end
			2'd2: begin cs = -c; sn = -s; end
			default: begin cs = s; sn = -c; end
		endcase
	endtask

	function automatic logic [19:0] scale_entry(longint r2, logic [15:0] scale);
		longint v;
		v = round_half_up(r2 * longint'(scale), FracBits + 12);
		return 20'(clip(v, OutMin, OutMax));
	endfunction

	// Model matrix T * Ry * Rx * Rz * S for one pose.
	task automatic predict_matrix(input pose_t p, output matrix_t m);
		longint sx, cx, sy, cy, sz, cz, one;
		longint r[9];
		cordic_sin_cos(p.angle_x, sx, cx);
		cordic_sin_cos(p.angle_y, sy, cy);
		cordic_sin_cos(p.angle_z, sz, cz);
		one  = longint'(1) <<< FracBits;
		r[0] = round_half_up(cy * cz * one + sy * sx * sz, FracBits);
		r[1] = cx * sz;
		r[2] = round_half_up(-(sy * cz * one) + cy * sx * sz, FracBits);
		r[3] = round_half_up(-(cy * sz * one) + sy * sx * cz, FracBits);
		r[4] = cx * cz;
		r[5] = round_half_up(sy * sz * one + cy * sx * cz, FracBits);
		r[6] = sy * cx;
		r[7] = -sx * one;
		r[8] = cy * cx;
		m.m00 = scale_entry(r[0], p.scale_x);
		m.m01 = scale_entry(r[1], p.scale_x);
		m.m02 = scale_entry(r[2], p.scale_x);
		m.m10 = scale_entry(r[3], p.scale_y);
		m.m11 = scale_entry(r[4], p.scale_y);
		m.m12 = scale_entry(r[5], p.scale_y);
		m.m20 = scale_entry(r[6], p.scale_z);
		m.m21 = scale_entry(r[7], p.scale_z);
		m.m22 = scale_entry(r[8], p.scale_z);
		m.trans_x = p.pos_x;
		m.trans_y = p.pos_y;
		m.trans_z = p.pos_z;
	endtask

	task automatic report_mismatch(input string what, input longint got,
			input longint want);
		$display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
		error_count++;
	endtask

	function automatic pose_t make_pose(logic [31:0] p, logic [15:0] ax,
			logic [15:0] ay, logic [15:0] az, logic [15:0] sc);
		pose_t q;
		q.pos_x = p; q.pos_y = ~p; q.pos_z = p ^ 32'h5A5A_A5A5;
		q.angle_x = ax; q.angle_y = ay; q.angle_z = az;
		q.scale_x = sc; q.scale_y = sc; q.scale_z = sc;
		return q;
	endfunction

	function automatic pose_t random_pose();
		pose_t q;
		q.pos_x = $urandom; q.pos_y = $urandom; q.pos_z = $urandom;
		q.angle_x = 16'($urandom); q.angle_y = 16'($urandom); q.angle_z = 16'($urandom);
		case ($urandom_range(0, 3))
			0: begin
				q.scale_x = 16'($urandom);
				q.scale_y = 16'($urandom);
				q.scale_z = 16'($urandom);
			end
			1: begin
				q.scale_x = 16'($urandom_range(0, 8192));
				q.scale_y = 16'($urandom_range(0, 8192));
				q.scale_z = 16'($urandom_range(0, 8192));
			end
			2: begin
				q.scale_x = 16'h1000; q.scale_y = 16'h1000; q.scale_z = 16'h1000;
				q.angle_x = 16'($urandom_range(0, 3)) << 14;
			end
			default: begin
				q.scale_x = 16'hFFFF; q.scale_y = 16'($urandom); q.scale_z = 16'h0000;
			end
		endcase
		return q;
	endfunction

	// Build the directed table: identities, quadrants, zero and full scale.
	task automatic build_directed_rows();
		pose_row_t row;
		matrix_t   ident;
		ident = '0;
		ident.m00 = 20'sd16384; ident.m11 = 20'sd16384; ident.m22 = 20'sd16384;
		row.has_known = 1'b1;
		row.pose = make_pose(32'h0, 16'h0, 16'h0, 16'h0, 16'h1000);
		row.known = ident;
		row.known.trans_x = row.pose.pos_x;
		row.known.trans_y = row.pose.pos_y;
		row.known.trans_z = row.pose.pos_z;
		directed_rows = {directed_rows, row};
		row.pose = make_pose(32'h7FFF_FFFF, 16'h1234, 16'hFFFF, 16'h8000, 16'h0000);
		row.known = '0;
		row.known.trans_x = row.pose.pos_x;
		row.known.trans_y = row.pose.pos_y;
		row.known.trans_z = row.pose.pos_z;
		directed_rows = {directed_rows, row};
		// Largest scale on the identity rotation stays inside the output range.
		row.pose = make_pose(32'h8000_0000, 16'h0, 16'h0, 16'h0, 16'hFFFF);
		row.known = '0;
		row.known.m00 = 20'sd262140;
		row.known.m11 = 20'sd262140;
		row.known.m22 = 20'sd262140;
		row.known.trans_x = row.pose.pos_x;
		row.known.trans_y = row.pose.pos_y;
		row.known.trans_z = row.pose.pos_z;
		directed_rows = {directed_rows, row};
		row.has_known = 1'b0;
		for (int q = 0; q < 4; q++) begin
			row.pose = make_pose(32'h0001_0000, 16'(q) << 14, 16'h0, 16'h0, 16'h1000);
			directed_rows = {directed_rows, row};
			row.pose = make_pose(32'hFFFF_0000, 16'h0, 16'(q) << 14, 16'h0, 16'h1000);
			directed_rows = {directed_rows, row};
			row.pose = make_pose(32'h1234_5678, 16'h0, 16'h0, 16'(q) << 14, 16'h1000);
			directed_rows = {directed_rows, row};
		end
		row.pose = make_pose(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		directed_rows = {directed_rows, row};
		row.pose = make_pose(32'h0, 16'h2000, 16'h6000, 16'hA000, 16'h8000);
		directed_rows = {directed_rows, row};
		row.pose = make_pose(32'hAAAA_5555, 16'h0001, 16'h7FFF, 16'h8001, 16'h0001);
		directed_rows = {directed_rows, row};
		row.pose = make_pose(32'h5555_AAAA, 16'hE000, 16'h2000, 16'h4000, 16'hC000);
		directed_rows = {directed_rows, row};
	endtask

	// Offer one pose and wait for its transaction; record the prediction.
	// Valid stays high into the next offer when no gap is drawn.
	task automatic send_pose(input pose_row_t row);
		matrix_t m;
		int      gap;
		gap = $urandom_range(0, 19) * ($urandom_range(0, 3) != 0);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		if (row.has_known)
			m = row.known;
		else
			predict_matrix(row.pose, m);
		in_valid <= 1'b1;
		in_data  <= row.pose;
		do @(posedge clk); while (!in_ready);
		matrix_queue = {matrix_queue, m};
		@(negedge clk);
	endtask

	// Sender process.
	initial begin
		pose_row_t row;
		in_valid      = 1'b0;
		in_data       = '0;
		arst_n        = 1'b0;
		hold_sink     = 1'b0;
		stimulus_done = 1'b0;
		error_count   = 0;
		build_directed_rows();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (directed_rows[i])
			send_pose(directed_rows[i]);
		in_valid <= 1'b0;
		// Pause until every expected matrix has come back.
		wait (matrix_queue.size() == 0);
		@(negedge clk);
		row.has_known = 1'b0;
		for (int n = 0; n < RandomPoses; n++) begin
			if (n == 200)
				hold_sink = 1'b1;
			if (n == 300)
				hold_sink = 1'b0;
			row.pose = random_pose();
			if (n >= 200 && n < 300) begin
				// Back-to-back offers while the sink is held off.
				in_valid <= 1'b1;
				in_data  <= row.pose;
				predict_matrix(row.pose, row.known);
				do @(posedge clk); while (!in_ready);
				matrix_queue = {matrix_queue, row.known};
				@(negedge clk);
			end else begin
				send_pose(row);
			end
		end
		in_valid <= 1'b0;
		stimulus_done = 1'b1;
	end

	// Receiver process: random stalls, plus one long hold-off.
	initial begin
		int stall;
		out_ready = 1'b0;
		hold_done = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(negedge clk);
				hold_done = 1'b1;
			end
			stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 19) : 0;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// Result checking against the oldest expected matrix.
	always @(posedge clk) begin
		matrix_t want;
		if (arst_n && out_valid && out_ready) begin
			if (matrix_queue.size() == 0) begin
				report_mismatch("unexpected transaction", 0, 0);
			end else begin
				want = matrix_queue.pop_front();
				if (out_data.m00 !== want.m00) report_mismatch("m00", out_data.m00, want.m00);
				if (out_data.m01 !== want.m01) report_mismatch("m01", out_data.m01, want.m01);
				if (out_data.m02 !== want.m02) report_mismatch("m02", out_data.m02, want.m02);
				if (out_data.m10 !== want.m10) report_mismatch("m10", out_data.m10, want.m10);
				if (out_data.m11 !== want.m11) report_mismatch("m11", out_data.m11, want.m11);
				if (out_data.m12 !== want.m12) report_mismatch("m12", out_data.m12, want.m12);
				if (out_data.m20 !== want.m20) report_mismatch("m20", out_data.m20, want.m20);
				if (out_data.m21 !== want.m21) report_mismatch("m21", out_data.m21, want.m21);
				if (out_data.m22 !== want.m22) report_mismatch("m22", out_data.m22, want.m22);
				if (out_data.trans_x !== want.trans_x)
					report_mismatch("trans_x", out_data.trans_x, want.trans_x);
				if (out_data.trans_y !== want.trans_y)
					report_mismatch("trans_y", out_data.trans_y, want.trans_y);
				if (out_data.trans_z !== want.trans_z)
					report_mismatch("trans_z", out_data.trans_z, want.trans_z);
			end
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End of run.
	initial begin
		idle_cycles = 0;
		fork
			begin
				wait (stimulus_done && matrix_queue.size() == 0);
				repeat (DrainCycles) @(posedge clk);
				if (matrix_queue.size() != 0)
					report_mismatch("matrices left over", matrix_queue.size(), 0);
				if (error_count == 0)
					$display("euler_trs_model_matrix_unit_tb: PASS");
				else
					$display("euler_trs_model_matrix_unit_tb: FAIL");
			end
			begin
				wait (idle_cycles >= IdleLimit);
				$display("euler_trs_model_matrix_unit_tb: FAIL");
			end
		join_any
		$finish;
	end

endmodule
